FILE: hw/rtl/pld_pkg.sv
// Package with shared constants for the pixel level threshold dither unit.
package pld_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned FactorW    = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ChanStages = 7;
  localparam int unsigned Stages     = ChanStages + 1;

  // Reciprocal multipliers: floor(x / d) == (x * Mul) >> DivShift over the ranges used.
  localparam int unsigned DivShift      = 23;
  localparam int unsigned DivHundredMul = 83887;
  localparam int unsigned DivFiftyMul   = 167773;

  localparam int unsigned MidLevel = 128;
  localparam int unsigned MaxLevel = 255;

  localparam logic [CfgIdxW-1:0] CfgMode       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRedGain    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGreenGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBlueGain   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBrightness = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgContrast   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTriLow     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgTriHigh    = 3'd7;

  localparam logic [ModeW-1:0] ModeSolid   = 2'd0;
  localparam logic [ModeW-1:0] ModeTritone = 2'd1;

  localparam logic [ModeW-1:0]   RstMode    = ModeSolid;
  localparam logic [DataW-1:0]   RstGain    = 8'd100;
  localparam logic [FactorW-1:0] RstFactor  = 7'd50;
  localparam logic [DataW-1:0]   RstTriLow  = 8'd64;
  localparam logic [DataW-1:0]   RstTriHigh = 8'd192;

endpackage

FILE: hw/rtl/pld_if.sv
// Valid/ready stream interfaces for source pixels and adjusted pixels.
interface pld_pixel_in_if;
  logic                     valid;
  logic                     ready;
  logic [pld_pkg::DataW-1:0] red_in;
  logic [pld_pkg::DataW-1:0] green_in;
  logic [pld_pkg::DataW-1:0] blue_in;
  logic [pld_pkg::DataW-1:0] column;
  logic [pld_pkg::DataW-1:0] row;

  modport source (output valid, red_in, green_in, blue_in, column, row, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, column, row, output ready);
endinterface

interface pld_pixel_out_if;
  logic                     valid;
  logic                     ready;
  logic [pld_pkg::DataW-1:0] red_out;
  logic [pld_pkg::DataW-1:0] green_out;
  logic [pld_pkg::DataW-1:0] blue_out;
  logic                     mono_white;

  modport source (output valid, red_out, green_out, blue_out, mono_white, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, mono_white, output ready);
endinterface

FILE: hw/rtl/pld_chan_adjust.sv
// Pipelined gain, contrast, brightness and clamp for one color channel.
module pld_chan_adjust (
  input  logic                                clk_i,
  input  logic [pld_pkg::ChanStages-1:0]      en_i,
  input  logic [pld_pkg::DataW-1:0]           level_i,
  input  logic [pld_pkg::DataW-1:0]           gain_i,
  input  logic [pld_pkg::FactorW-1:0]         contrast_i,
  input  logic [pld_pkg::FactorW-1:0]         brightness_i,
  output logic [pld_pkg::DataW-1:0]           level_o
);

  // Stage 0: raw gain product.
  logic [15:0] gain_prod_q;
  // Stage 1: gain product divided by 100.
  logic [32:0] gain_recip;
  logic [9:0]  scaled_d, scaled_q;
  // Stage 2: contrast product around the mid level.
  logic signed [10:0] centered;
  logic signed [18:0] con_prod_d, con_prod_q;
  // Stage 3: contrast quotient magnitude and sign.
  logic [18:0] con_mag;
  logic [36:0] con_recip;
  logic [10:0] con_quo_d, con_quo_q;
  logic        con_neg_q;
  // Stage 4: brightness product.
  logic signed [11:0] con_level;
  logic signed [19:0] bri_prod_d, bri_prod_q;
  // Stage 5: brightness quotient magnitude and sign.
  logic [19:0] bri_mag;
  logic [37:0] bri_recip;
  logic [11:0] bri_quo_d, bri_quo_q;
  logic        bri_neg_q;
  // Stage 6: clamped level.
  logic [pld_pkg::DataW-1:0] clamp_d, clamp_q;

  assign gain_recip = 33'(gain_prod_q) * 33'(pld_pkg::DivHundredMul);
  assign scaled_d   = gain_recip[pld_pkg::DivShift +: 10];

  assign centered   = $signed({1'b0, scaled_q}) - 11'sd128;
  assign con_prod_d = 19'(centered) * $signed({12'b0, contrast_i});

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign con_mag   = con_prod_q[18] ? 19'(-con_prod_q) : 19'(con_prod_q);
  assign con_recip = 37'(con_mag) * 37'(pld_pkg::DivFiftyMul);
  assign con_quo_d = con_recip[pld_pkg::DivShift +: 11];

  assign con_level  = con_neg_q ? (12'sd128 - $signed({1'b0, con_quo_q}))
                                : (12'sd128 + $signed({1'b0, con_quo_q}));
  assign bri_prod_d = 20'(con_level) * $signed({13'b0, brightness_i});

  assign bri_mag   = bri_prod_q[19] ? 20'(-bri_prod_q) : 20'(bri_prod_q);
  assign bri_recip = 38'(bri_mag) * 38'(pld_pkg::DivFiftyMul);
  assign bri_quo_d = bri_recip[pld_pkg::DivShift +: 12];

  always_comb begin
    if (bri_neg_q) begin
      clamp_d = '0;
    end else if (bri_quo_q > 12'(pld_pkg::MaxLevel)) begin
      clamp_d = pld_pkg::DataW'(pld_pkg::MaxLevel);
    end else begin
      clamp_d = bri_quo_q[pld_pkg::DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) gain_prod_q <= 16'(level_i) * 16'(gain_i);
    if (en_i[1]) scaled_q <= scaled_d;
    if (en_i[2]) con_prod_q <= con_prod_d;
    if (en_i[3]) begin
      con_quo_q <= con_quo_d;
      con_neg_q <= con_prod_q[18];
    end
    if (en_i[4]) bri_prod_q <= bri_prod_d;
    if (en_i[5]) begin
      bri_quo_q <= bri_quo_d;
      bri_neg_q <= bri_prod_q[19];
    end
    if (en_i[6]) clamp_q <= clamp_d;
  end

  assign level_o = clamp_q;

endmodule

FILE: hw/rtl/pixel_level_threshold_dither_unit.sv
// Top level: configuration registers, pipeline control, gray level and mono decision.
// Each input pixel passes through the channel adjust stages and then the output register
// before its result is offered at the output. Throughput: one pixel per cycle while the
// output accepts; each of the 8 register stages holds one pixel and advances whenever
// the stage after it moves or is empty, so stalls lose nothing.
// Reset clears all stage valid bits and loads the configuration registers with defaults.
module pixel_level_threshold_dither_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pld_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pld_pkg::DataW-1:0]     cfg_data_i,
  pld_pixel_in_if.sink                  pix_i,
  pld_pixel_out_if.source               pix_o
);

  localparam int unsigned Last = pld_pkg::Stages - 1;

  logic [pld_pkg::ModeW-1:0]   mode_q;
  logic [pld_pkg::DataW-1:0]   red_gain_q, green_gain_q, blue_gain_q;
  logic [pld_pkg::FactorW-1:0] brightness_q, contrast_q;
  logic [pld_pkg::DataW-1:0]   tri_low_q, tri_high_q;

  logic [pld_pkg::Stages-1:0]     valid_q;
  logic [pld_pkg::Stages-1:0]     en;
  logic [pld_pkg::ChanStages-1:0] parity_q;

  logic [pld_pkg::DataW-1:0] red_adj, green_adj, blue_adj;
  logic [12:0]               gray_sum;
  logic [pld_pkg::DataW-1:0] gray;
  logic [pld_pkg::DataW-1:0] lvl_lo, lvl_hi;
  logic                      white_d;

  logic [pld_pkg::DataW-1:0] red_q, green_q, blue_q;
  logic                      white_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= pld_pkg::RstMode;
      red_gain_q   <= pld_pkg::RstGain;
      green_gain_q <= pld_pkg::RstGain;
      blue_gain_q  <= pld_pkg::RstGain;
      brightness_q <= pld_pkg::RstFactor;
      contrast_q   <= pld_pkg::RstFactor;
      tri_low_q    <= pld_pkg::RstTriLow;
      tri_high_q   <= pld_pkg::RstTriHigh;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pld_pkg::CfgMode:       mode_q       <= cfg_data_i[pld_pkg::ModeW-1:0];
        pld_pkg::CfgRedGain:    red_gain_q   <= cfg_data_i;
        pld_pkg::CfgGreenGain:  green_gain_q <= cfg_data_i;
        pld_pkg::CfgBlueGain:   blue_gain_q  <= cfg_data_i;
        pld_pkg::CfgBrightness: brightness_q <= cfg_data_i[pld_pkg::FactorW-1:0];
        pld_pkg::CfgContrast:   contrast_q   <= cfg_data_i[pld_pkg::FactorW-1:0];
        pld_pkg::CfgTriLow:     tri_low_q    <= cfg_data_i;
        pld_pkg::CfgTriHigh:    tri_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[Last] = !valid_q[Last] || pix_o.ready;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= pix_i.valid;
      for (int k = 1; k < pld_pkg::Stages; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) parity_q[0] <= pix_i.column[0] ^ pix_i.row[0];
    for (int k = 1; k < pld_pkg::ChanStages; k++) begin
      if (en[k]) parity_q[k] <= parity_q[k-1];
    end
  end

  pld_chan_adjust u_red (
    .clk_i        (clk_i),
    .en_i         (en[pld_pkg::ChanStages-1:0]),
    .level_i      (pix_i.red_in),
    .gain_i       (red_gain_q),
    .contrast_i   (contrast_q),
    .brightness_i (brightness_q),
    .level_o      (red_adj)
  );

  pld_chan_adjust u_green (
    .clk_i        (clk_i),
    .en_i         (en[pld_pkg::ChanStages-1:0]),
    .level_i      (pix_i.green_in),
    .gain_i       (green_gain_q),
    .contrast_i   (contrast_q),
    .brightness_i (brightness_q),
    .level_o      (green_adj)
  );

  pld_chan_adjust u_blue (
    .clk_i        (clk_i),
    .en_i         (en[pld_pkg::ChanStages-1:0]),
    .level_i      (pix_i.blue_in),
    .gain_i       (blue_gain_q),
    .contrast_i   (contrast_q),
    .brightness_i (brightness_q),
    .level_o      (blue_adj)
  );

  // Channels are never negative here, so the division by 32 is a plain shift.
  assign gray_sum = 13'(red_adj) * 13'd11 + 13'(green_adj) * 13'd16 + 13'(blue_adj) * 13'd5;
  assign gray     = gray_sum[12:5];

  assign lvl_lo = (tri_low_q > tri_high_q) ? tri_high_q : tri_low_q;
  assign lvl_hi = (tri_low_q > tri_high_q) ? tri_low_q : tri_high_q;

  always_comb begin
    case (mode_q)
      pld_pkg::ModeSolid: begin
        white_d = gray >= pld_pkg::DataW'(pld_pkg::MidLevel);
      end
      pld_pkg::ModeTritone: begin
        if (gray < lvl_lo) begin
          white_d = 1'b0;
        end else if (gray > lvl_hi) begin
          white_d = 1'b1;
        end else begin
          white_d = parity_q[pld_pkg::ChanStages-1];
        end
      end
      default: white_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[Last]) begin
      red_q   <= red_adj;
      green_q <= green_adj;
      blue_q  <= blue_adj;
      white_q <= white_d;
    end
  end

  assign pix_o.valid      = valid_q[Last];
  assign pix_o.red_out    = red_q;
  assign pix_o.green_out  = green_q;
  assign pix_o.blue_out   = blue_q;
  assign pix_o.mono_white = white_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the pixel level threshold dither unit.
`timescale 1ns / 1ps

module tb;

  localparam int ClkHalf    = 10;
  localparam int ResetCycles = 8;
  localparam int CycleLimit = 400000;
  localparam int IdleMax    = 13;
  localparam int HoldCycles = 150;
  localparam int RandPhases = 12;
  localparam int PhaseItems = 68;

  localparam int MidLvl     = int'(pld_pkg::MidLevel);
  localparam int MaxLvl     = int'(pld_pkg::MaxLevel);
  localparam int GainUnit   = 100;
  localparam int FactorUnit = 50;
  localparam int DrainWait  = int'(pld_pkg::Stages) + 4;

  localparam logic [pld_pkg::ModeW-1:0] ModeBlack  = 2'd2;
  localparam logic [pld_pkg::ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [pld_pkg::DataW-1:0] red;
    logic [pld_pkg::DataW-1:0] green;
    logic [pld_pkg::DataW-1:0] blue;
    logic [pld_pkg::DataW-1:0] column;
    logic [pld_pkg::DataW-1:0] row;
  } src_pixel_t;

  typedef struct packed {
    logic [pld_pkg::DataW-1:0] red;
    logic [pld_pkg::DataW-1:0] green;
    logic [pld_pkg::DataW-1:0] blue;
    logic                      mono_white;
  } adj_pixel_t;

  typedef struct packed {
    logic [pld_pkg::ModeW-1:0]   mode;
    logic [pld_pkg::DataW-1:0]   red_gain;
    logic [pld_pkg::DataW-1:0]   green_gain;
    logic [pld_pkg::DataW-1:0]   blue_gain;
    logic [pld_pkg::FactorW-1:0] brightness;
    logic [pld_pkg::FactorW-1:0] contrast;
    logic [pld_pkg::DataW-1:0]   tri_low;
    logic [pld_pkg::DataW-1:0]   tri_high;
  } adjust_cfg_t;

  class pixel_scoreboard;
    adj_pixel_t  expected_pixels[$];
    int unsigned failures;

    function logic [pld_pkg::DataW-1:0] adjust_level(logic [pld_pkg::DataW-1:0] v,
                                                     logic [pld_pkg::DataW-1:0] gain,
                                                     adjust_cfg_t cfg);
      int lev;
      lev = int'(v) * int'(gain) / GainUnit;
      // Signed arithmetic here so that the contrast step truncates toward zero.
      lev = (lev - MidLvl) * int'(cfg.contrast) / FactorUnit + MidLvl;
      lev = lev * int'(cfg.brightness) / FactorUnit;
      if (lev < 0) begin
        lev = 0;
      end else if (lev > MaxLvl) begin
        lev = MaxLvl;
      end
      return lev[pld_pkg::DataW-1:0];
    endfunction

    function adj_pixel_t predict_adjusted(src_pixel_t px, adjust_cfg_t cfg);
      adj_pixel_t res;
      int         gray;
      int         lo;
      int         hi;
      res.red   = adjust_level(px.red, cfg.red_gain, cfg);
      res.green = adjust_level(px.green, cfg.green_gain, cfg);
      res.blue  = adjust_level(px.blue, cfg.blue_gain, cfg);
      gray = (11 * int'(res.red) + 16 * int'(res.green) + 5 * int'(res.blue)) / 32;
      lo = (cfg.tri_low < cfg.tri_high) ? int'(cfg.tri_low) : int'(cfg.tri_high);
      hi = (cfg.tri_low < cfg.tri_high) ? int'(cfg.tri_high) : int'(cfg.tri_low);
      case (cfg.mode)
        pld_pkg::ModeSolid: begin
          res.mono_white = (gray >= MidLvl);
        end
        pld_pkg::ModeTritone: begin
          if (gray < lo) begin
            res.mono_white = 1'b0;
          end else if (gray > hi) begin
            res.mono_white = 1'b1;
          end else begin
            res.mono_white = px.column[0] ^ px.row[0];
          end
        end
        default: begin
          res.mono_white = 1'b0;
        end
      endcase
      return res;
    endfunction

    function void note_pixel(src_pixel_t px, adjust_cfg_t cfg);
      expected_pixels.push_back(predict_adjusted(px, cfg));
    endfunction

    function void check_pixel(adj_pixel_t got);
      adj_pixel_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: r=%0d g=%0d b=%0d w=%0b",
                   got.red, got.green, got.blue, got.mono_white);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.mono_white !== want.mono_white) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected r=%0d g=%0d b=%0d w=%0b, got r=%0d g=%0d b=%0d w=%0b",
                   want.red, want.green, want.blue, want.mono_white,
                   got.red, got.green, got.blue, got.mono_white);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                         cfg_we_i;
  logic [pld_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pld_pkg::DataW-1:0]    cfg_data_i;

  pld_pixel_in_if  pix_in ();
  pld_pixel_out_if pix_out ();

  pixel_level_threshold_dither_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  pixel_scoreboard sb = new();
  adjust_cfg_t     cfg_shadow;
  int unsigned     tx_gap_max;
  int unsigned     rx_stall_max;
  bit              rx_hold_req = 1'b0;
  int unsigned     cycle_count = 0;

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic adjust_cfg_t neutral_cfg(logic [pld_pkg::ModeW-1:0] mode);
    adjust_cfg_t c;
    c.mode       = mode;
    c.red_gain   = pld_pkg::RstGain;
    c.green_gain = pld_pkg::RstGain;
    c.blue_gain  = pld_pkg::RstGain;
    c.brightness = pld_pkg::RstFactor;
    c.contrast   = pld_pkg::RstFactor;
    c.tri_low    = pld_pkg::RstTriLow;
    c.tri_high   = pld_pkg::RstTriHigh;
    return c;
  endfunction

  function automatic logic [pld_pkg::DataW-1:0] pick_gain();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return 8'd255;
      2:       return pld_pkg::RstGain;
      3:       return 8'($urandom_range(255, 0));
      default: return 8'($urandom_range(200, 0));
    endcase
  endfunction

  function automatic logic [pld_pkg::FactorW-1:0] pick_factor();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return 7'd127;
      2:       return pld_pkg::RstFactor;
      3:       return 7'($urandom_range(127, 0));
      default: return 7'($urandom_range(100, 0));
    endcase
  endfunction

  task automatic write_reg(logic [pld_pkg::CfgIdxW-1:0] idx, logic [pld_pkg::DataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic apply_cfg(adjust_cfg_t c);
    write_reg(pld_pkg::CfgMode, pld_pkg::DataW'(c.mode));
    write_reg(pld_pkg::CfgRedGain, c.red_gain);
    write_reg(pld_pkg::CfgGreenGain, c.green_gain);
    write_reg(pld_pkg::CfgBlueGain, c.blue_gain);
    write_reg(pld_pkg::CfgBrightness, pld_pkg::DataW'(c.brightness));
    write_reg(pld_pkg::CfgContrast, pld_pkg::DataW'(c.contrast));
    write_reg(pld_pkg::CfgTriLow, c.tri_low);
    write_reg(pld_pkg::CfgTriHigh, c.tri_high);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_shadow = c;
  endtask

  // Called at a rising edge; returns at the edge of the transfer with valid still high.
  task automatic send_pixel(src_pixel_t px);
    int unsigned gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= px.red;
    pix_in.green_in <= px.green;
    pix_in.blue_in  <= px.blue;
    pix_in.column   <= px.column;
    pix_in.row      <= px.row;
    do @(posedge clk_i); while (!pix_in.ready);
    sb.note_pixel(px, cfg_shadow);
  endtask

  task automatic drain();
    pix_in.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall;
    adj_pixel_t  got;
    bit          hold_done;
    hold_done = 1'b0;
    pix_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req && !hold_done) begin
        stall = HoldCycles;
        hold_done = 1'b1;
      end else begin
        stall = $urandom_range(rx_stall_max, 0);
      end
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pix_out.ready <= 1'b1;
      do @(posedge clk_i); while (!pix_out.valid);
      got.red        = pix_out.red_out;
      got.green      = pix_out.green_out;
      got.blue       = pix_out.blue_out;
      got.mono_white = pix_out.mono_white;
      sb.check_pixel(got);
    end
  end

  initial begin : stimulus
    adjust_cfg_t c;
    src_pixel_t  px;
    int unsigned pick;
    tx_gap_max      = IdleMax;
    rx_stall_max    = IdleMax;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    pix_in.valid    <= 1'b0;
    pix_in.red_in   <= '0;
    pix_in.green_in <= '0;
    pix_in.blue_in  <= '0;
    pix_in.column   <= '0;
    pix_in.row      <= '0;
    cfg_shadow      = neutral_cfg(pld_pkg::RstMode);
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: solid threshold around mid gray, coordinate extremes.
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'd127, 8'd127, 8'd127, 8'd1, 8'd0});
    send_pixel('{8'd128, 8'd128, 8'd128, 8'd0, 8'd1});
    send_pixel('{8'd255, 8'd0, 8'd0, 8'd170, 8'd191});
    send_pixel('{8'd0, 8'd255, 8'd0, 8'd85, 8'd200});
    drain();

    // Tritone: below, at and above both levels, both checkerboard phases.
    apply_cfg(neutral_cfg(pld_pkg::ModeTritone));
    send_pixel('{8'd63, 8'd63, 8'd63, 8'd1, 8'd0});
    send_pixel('{8'd64, 8'd64, 8'd64, 8'd1, 8'd0});
    send_pixel('{8'd64, 8'd64, 8'd64, 8'd1, 8'd1});
    send_pixel('{8'd192, 8'd192, 8'd192, 8'd2, 8'd1});
    send_pixel('{8'd193, 8'd193, 8'd193, 8'd0, 8'd0});
    drain();

    // Tritone levels given in reverse order are swapped before use.
    c = neutral_cfg(pld_pkg::ModeTritone);
    c.tri_low  = 8'd200;
    c.tri_high = 8'd50;
    apply_cfg(c);
    send_pixel('{8'd49, 8'd49, 8'd49, 8'd1, 8'd0});
    send_pixel('{8'd201, 8'd201, 8'd201, 8'd0, 8'd0});
    send_pixel('{8'd100, 8'd100, 8'd100, 8'd3, 8'd0});
    drain();

    apply_cfg(neutral_cfg(ModeBlack));
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd1, 8'd0});
    drain();
    apply_cfg(neutral_cfg(ModeUnused));
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd1, 8'd0});
    drain();

    // Largest gains and factors: saturation at both ends of the clamp.
    c = neutral_cfg(pld_pkg::ModeSolid);
    c.red_gain   = 8'd255;
    c.green_gain = 8'd255;
    c.blue_gain  = 8'd255;
    c.brightness = 7'd127;
    c.contrast   = 7'd127;
    apply_cfg(c);
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0});
    send_pixel('{8'd40, 8'd40, 8'd40, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    drain();

    c = neutral_cfg(pld_pkg::ModeSolid);
    c.red_gain   = '0;
    c.green_gain = '0;
    c.blue_gain  = '0;
    c.brightness = '0;
    c.contrast   = '0;
    apply_cfg(c);
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    drain();

    for (int phase = 0; phase < RandPhases; phase++) begin
      pick = $urandom_range(7, 0);
      c.mode       = (pick < 3) ? pld_pkg::ModeSolid : (pick < 6) ? pld_pkg::ModeTritone :
                     (pick == 6) ? ModeBlack : ModeUnused;
      c.red_gain   = pick_gain();
      c.green_gain = pick_gain();
      c.blue_gain  = pick_gain();
      c.brightness = pick_factor();
      c.contrast   = pick_factor();
      c.tri_low    = 8'($urandom_range(255, 0));
      c.tri_high   = ($urandom_range(7, 0) == 0) ? c.tri_low : 8'($urandom_range(255, 0));
      apply_cfg(c);
      case (phase % 4)
        0: begin tx_gap_max = IdleMax; rx_stall_max = IdleMax; end
        1: begin tx_gap_max = 0;       rx_stall_max = 0;       end
        2: begin tx_gap_max = 0;       rx_stall_max = IdleMax; end
        default: begin tx_gap_max = IdleMax; rx_stall_max = 0; end
      endcase
      // Once, the output side holds off long enough for the pipeline to back up.
      if (phase == 2) begin
        rx_hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        px.red    = 8'($urandom_range(255, 0));
        px.green  = 8'($urandom_range(255, 0));
        px.blue   = 8'($urandom_range(255, 0));
        px.column = 8'($urandom_range(255, 0));
        px.row    = 8'($urandom_range(255, 0));
        send_pixel(px);
      end
      drain();
    end

    repeat (int'(pld_pkg::Stages) * 2) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
